>>> hw/rtl/ngbt_pkg.sv
// ngbt_pkg: shared types and constants of the neighbour table with aging
// holds the entry record layout, result status codes and controller states
// depends on nothing
`default_nettype none

package ngbt_pkg;

   // default table shape
   localparam int TABLE_DEPTH_DEF = 32;
   localparam int AGE_WIDTH_DEF   = 16;

   // fixed field widths
   localparam int ID_W      = 16;
   localparam int POS_W     = 32;
   localparam int THR_W     = 16;
   localparam int SLOT_W    = 5;
   localparam int ECOUNT_W  = 6;

   localparam logic [THR_W-1:0] DEAD_THR_RESET = 16'd10;

   // one stored neighbour, minus its age
   typedef struct packed {
      logic              changed;
      logic [ID_W-1:0]   id;
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef enum logic [1:0] {
      ST_UPDATED = 2'd0,
      ST_ADDED   = 2'd1,
      ST_FULL    = 2'd2,
      ST_PURGED  = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      OP_BEACON = 1'b0,
      OP_PURGE  = 1'b1
   } opcode_type;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SEARCH = 7'b0000010,
      S_AGE    = 7'b0000100,
      S_PREAD  = 7'b0001000,
      S_PWAIT  = 7'b0010000,
      S_PCOPY  = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

>>> hw/rtl/neighbour_table_with_aging.sv
// neighbour_table_with_aging: packed neighbour table with age counters, top level
// beacon: id search pass, then age pass on a hit or an add; a refused add skips the age pass
//   (one ram read per slot visited in each pass, then the finish state)
// purge: age read and compare per slot; a dead entry is replaced by a copy of the last entry
// throughput: one word at a time, next word taken once the controller is back in idle
// reset (synchronous): table empty, threshold 10, no result pending; ram contents undefined
`default_nettype none

module neighbour_table_with_aging #(
   parameter int TABLE_DEPTH = ngbt_pkg::TABLE_DEPTH_DEF,
   parameter int AGE_WIDTH   = ngbt_pkg::AGE_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_opcode,
   input  wire logic [ngbt_pkg::ID_W-1:0]         req_node_id,
   input  wire logic signed [ngbt_pkg::POS_W-1:0] req_pos_x,
   input  wire logic signed [ngbt_pkg::POS_W-1:0] req_pos_y,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [1:0]                             rsp_status,
   output logic [ngbt_pkg::SLOT_W-1:0]            rsp_slot,
   output logic                                   rsp_moved,
   output logic [ngbt_pkg::ECOUNT_W-1:0]          rsp_entry_count,
   output logic [ngbt_pkg::ECOUNT_W-1:0]          rsp_removed_count,
   // threshold register write
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ngbt_pkg::THR_W-1:0]        csr_dead_threshold
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (AGE_WIDTH > ngbt_pkg::THR_W) ? AGE_WIDTH : ngbt_pkg::THR_W;

   // controller state
   ngbt_pkg::state_type               state_ff, state_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [ngbt_pkg::THR_W-1:0]        thr_ff, thr_in;

   // captured request word
   logic                              op_ff, op_in;
   logic [ngbt_pkg::ID_W-1:0]         id_ff, id_in;
   logic [ngbt_pkg::POS_W-1:0]        x_ff, x_in;
   logic [ngbt_pkg::POS_W-1:0]        y_ff, y_in;

   // scan pointer: ra is the next ram address, paddr the one whose data is back
   logic [CNT_W-1:0]                  ra_ff, ra_in;
   logic                              pend_ff, pend_in;
   logic [IDX_W-1:0]                  paddr_ff, paddr_in;

   // result being built
   logic [IDX_W-1:0]                  slot_ff, slot_in;
   ngbt_pkg::status_type              status_ff, status_in;
   logic                              moved_ff, moved_in;
   logic [CNT_W-1:0]                  removed_ff, removed_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   ngbt_pkg::status_type              rsp_status_ff;
   logic [ngbt_pkg::SLOT_W-1:0]       rsp_slot_ff;
   logic                              rsp_moved_ff;
   logic [ngbt_pkg::ECOUNT_W-1:0]     rsp_count_ff;
   logic [ngbt_pkg::ECOUNT_W-1:0]     rsp_removed_ff;
   logic                              rsp_load;

   // ram ports
   logic                              rec_we, rec_re;
   logic [IDX_W-1:0]                  rec_waddr, rec_raddr;
   ngbt_pkg::rec_type                 rec_wdata, rec_rdata;
   logic                              age_we, age_re;
   logic [IDX_W-1:0]                  age_waddr, age_raddr;
   logic [AGE_WIDTH-1:0]              age_wdata, age_rdata;

   // datapath helpers
   logic                              hit;
   logic                              pos_diff;
   logic                              search_done;
   logic                              dead;
   logic [AGE_WIDTH-1:0]              age_next;
   logic [CNT_W-1:0]                  count_m1;
   logic [31:0]                       slot_wide;
   logic [31:0]                       count_wide;
   logic [31:0]                       removed_wide;

   // record store: id, position and changed mark
   ngbt_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (ngbt_pkg::REC_W),
      .AW    (IDX_W)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wdata),
      .rd_en   (rec_re),
      .rd_addr (rec_raddr),
      .rd_data (rec_rdata)
   );

   // age store, kept apart so the age pass never touches the records
   ngbt_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (AGE_WIDTH),
      .AW    (IDX_W)
   ) u_age_ram (
      .clock   (clock),
      .wr_en   (age_we),
      .wr_addr (age_waddr),
      .wr_data (age_wdata),
      .rd_en   (age_re),
      .rd_addr (age_raddr),
      .rd_data (age_rdata)
   );

   // id compare on the record that just came back from the ram
   assign hit      = pend_ff && (rec_rdata.id == id_ff);
   assign pos_diff = (rec_rdata.x != x_ff) || (rec_rdata.y != y_ff);

   // last valid slot has been compared, or the table is empty
   assign search_done = pend_ff ? ((CNT_W'(paddr_ff) + CNT_W'(1)) == count_ff)
                                : (count_ff == '0);

   // purge test: age strictly above the threshold
   assign dead = CMP_W'(age_rdata) > CMP_W'(thr_ff);

   // saturating increment, beaconing slot goes back to zero
   assign age_next = (paddr_ff == slot_ff) ? '0 :
                     (&age_rdata)          ? age_rdata :
                                             age_rdata + AGE_WIDTH'(1);

   assign count_m1 = count_ff - CNT_W'(1);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      op_in      = op_ff;
      id_in      = id_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      ra_in      = ra_ff;
      pend_in    = 1'b0;
      paddr_in   = paddr_ff;
      slot_in    = slot_ff;
      status_in  = status_ff;
      moved_in   = moved_ff;
      removed_in = removed_ff;
      rsp_load   = 1'b0;

      rec_we            = 1'b0;
      rec_waddr         = paddr_ff;
      rec_wdata.changed = 1'b1;
      rec_wdata.id      = id_ff;
      rec_wdata.x       = x_ff;
      rec_wdata.y       = y_ff;
      rec_re            = 1'b0;
      rec_raddr         = ra_ff[IDX_W-1:0];
      age_we            = 1'b0;
      age_waddr         = paddr_ff;
      age_wdata         = age_next;
      age_re            = 1'b0;
      age_raddr         = ra_ff[IDX_W-1:0];

      unique case (state_ff)
         ngbt_pkg::S_IDLE: begin
            // capture the word; req_stall is low only here
            if (req_valid) begin
               op_in      = req_opcode;
               id_in      = req_node_id;
               x_in       = req_pos_x;
               y_in       = req_pos_y;
               ra_in      = '0;
               removed_in = '0;
               slot_in    = '0;
               moved_in   = 1'b0;
               state_in   = (req_opcode == ngbt_pkg::OP_PURGE) ? ngbt_pkg::S_PREAD
                                                               : ngbt_pkg::S_SEARCH;
            end
         end

         ngbt_pkg::S_SEARCH: begin
            // streaming id lookup, one read issued per cycle, first match wins
            if (hit) begin
               rec_we    = pos_diff;
               rec_waddr = paddr_ff;
               slot_in   = paddr_ff;
               moved_in  = pos_diff;
               status_in = ngbt_pkg::ST_UPDATED;
               ra_in     = '0;
               state_in  = ngbt_pkg::S_AGE;
            end else if (search_done) begin
               if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                  // full table, nothing changes, ages included
                  status_in = ngbt_pkg::ST_FULL;
                  slot_in   = '0;
                  moved_in  = 1'b0;
                  state_in  = ngbt_pkg::S_FINISH;
               end else begin
                  // append at the end of the packed table
                  rec_we    = 1'b1;
                  rec_waddr = count_ff[IDX_W-1:0];
                  slot_in   = count_ff[IDX_W-1:0];
                  count_in  = count_ff + CNT_W'(1);
                  moved_in  = 1'b1;
                  status_in = ngbt_pkg::ST_ADDED;
                  ra_in     = '0;
                  state_in  = ngbt_pkg::S_AGE;
               end
            end else if (ra_ff < count_ff) begin
               rec_re   = 1'b1;
               pend_in  = 1'b1;
               paddr_in = ra_ff[IDX_W-1:0];
               ra_in    = ra_ff + CNT_W'(1);
            end
         end

         ngbt_pkg::S_AGE: begin
            // read-modify-write pipeline: write slot n while reading slot n+1
            age_we = pend_ff;
            if (ra_ff < count_ff) begin
               age_re   = 1'b1;
               pend_in  = 1'b1;
               paddr_in = ra_ff[IDX_W-1:0];
               ra_in    = ra_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               state_in = ngbt_pkg::S_FINISH;
            end
         end

         ngbt_pkg::S_PREAD: begin
            if (ra_ff < count_ff) begin
               age_re   = 1'b1;
               state_in = ngbt_pkg::S_PWAIT;
            end else begin
               status_in = ngbt_pkg::ST_PURGED;
               slot_in   = '0;
               moved_in  = 1'b0;
               state_in  = ngbt_pkg::S_FINISH;
            end
         end

         ngbt_pkg::S_PWAIT: begin
            if (dead) begin
               // fetch the last entry to fill the hole
               rec_re    = 1'b1;
               age_re    = 1'b1;
               rec_raddr = count_m1[IDX_W-1:0];
               age_raddr = count_m1[IDX_W-1:0];
               state_in  = ngbt_pkg::S_PCOPY;
            end else begin
               ra_in    = ra_ff + CNT_W'(1);
               state_in = ngbt_pkg::S_PREAD;
            end
         end

         ngbt_pkg::S_PCOPY: begin
            // move last entry down, then recheck the same slot
            rec_we     = 1'b1;
            rec_waddr  = ra_ff[IDX_W-1:0];
            rec_wdata  = rec_rdata;
            age_we     = 1'b1;
            age_waddr  = ra_ff[IDX_W-1:0];
            age_wdata  = age_rdata;
            count_in   = count_m1;
            removed_in = removed_ff + CNT_W'(1);
            state_in   = ngbt_pkg::S_PREAD;
         end

         ngbt_pkg::S_FINISH: begin
            // hand the word over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ngbt_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = ngbt_pkg::S_IDLE;
         end
      endcase
   end

   // threshold register, always writable
   assign csr_ready = 1'b1;
   assign thr_in    = csr_valid ? csr_dead_threshold : thr_ff;

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // field width adjust for the response word
   assign slot_wide    = 32'(slot_ff);
   assign count_wide   = 32'(count_ff);
   assign removed_wide = 32'(removed_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ngbt_pkg::S_IDLE;
         count_ff     <= '0;
         thr_ff       <= ngbt_pkg::DEAD_THR_RESET;
         ra_ff        <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         thr_ff       <= thr_in;
         ra_ff        <= ra_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      id_ff      <= id_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      paddr_ff   <= paddr_in;
      slot_ff    <= slot_in;
      status_ff  <= status_in;
      moved_ff   <= moved_in;
      removed_ff <= removed_in;
      if (rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_slot_ff    <= slot_wide[ngbt_pkg::SLOT_W-1:0];
         rsp_moved_ff   <= moved_ff;
         rsp_count_ff   <= count_wide[ngbt_pkg::ECOUNT_W-1:0];
         // a beacon never removes anything
         rsp_removed_ff <= (op_ff == ngbt_pkg::OP_PURGE) ?
                           removed_wide[ngbt_pkg::ECOUNT_W-1:0] : '0;
      end
   end

   assign req_stall         = (state_ff != ngbt_pkg::S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_moved         = rsp_moved_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_removed_count = rsp_removed_ff;

`ifndef NO_ASSERTIONS
   // table never holds more entries than it has slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // a response only appears after the controller finished an item
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ngbt_pkg::S_FINISH))
      else $error("response raised outside finish");

   // scan data in flight always refers to a live slot
   a_pend_in_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (CNT_W'(paddr_ff) < count_ff))
      else $error("pending read beyond table end");

   // a full report only comes from a full table
   a_full_report: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && (rsp_status_ff == ngbt_pkg::ST_FULL))
         |-> (count_ff == CNT_W'(TABLE_DEPTH)))
      else $error("table full reported with free slots");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/ngbt_ram.sv
// ngbt_ram: simple dual port synchronous memory, one write and one read port
// read data is registered, available in the cycle after the read; no dependencies
`default_nettype none

module ngbt_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 16,
   parameter int AW    = 5
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
